[hw/rtl/mwpm_pkg.sv]
`default_nettype none
package mwpm_pkg;

  localparam int CMD_W  = 16;
  localparam int SUM_W  = CMD_W + 2;   // f +/- s +/- t never overflows
  localparam int MAG_W  = SUM_W - 1;   // magnitude of a sum, at most 3 * 32768
  localparam int QUO_W  = 15;          // quotient never exceeds 16384
  localparam int DIV_STEPS = QUO_W - 1; // first quotient bit is taken in the front end
  localparam int NWHEEL = 4;

  localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(16384);
  localparam logic signed [CMD_W-1:0] POS_ONE = CMD_W'(16384);
  localparam logic signed [CMD_W-1:0] NEG_ONE = -CMD_W'(16384);

  // wheel order: front left, front right, back left, back right
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [QUO_W-1:0] quo_t;

  typedef struct packed {
    logic                     scale;
    mag_t                     m;
    logic [NWHEEL-1:0]        neg;
    logic [NWHEEL-1:0][MAG_W-1:0] rem;
    logic [NWHEEL-1:0][QUO_W-1:0] quo;
  } div_t;

endpackage
`default_nettype wire

[hw/rtl/mwpm_front.sv]
`default_nettype none
module mwpm_front import mwpm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    up_vld,
  output logic                         up_rdy,
  input  wire logic signed [CMD_W-1:0] forward_cmd,
  input  wire logic signed [CMD_W-1:0] strafe_cmd,
  input  wire logic signed [CMD_W-1:0] turn_cmd,
  output logic                         dn_vld,
  input  wire logic                    dn_rdy,
  output div_t                         dn_data
);

  // stage a: wheel sums
  logic vld_a, rdy_a;
  logic [NWHEEL-1:0][SUM_W-1:0] p_a;
  // stage b: sign, magnitude, pairwise max
  logic vld_b, rdy_b;
  logic [NWHEEL-1:0]            neg_b;
  logic [NWHEEL-1:0][MAG_W-1:0] mag_b;
  mag_t max01_b, max23_b;
  // stage c: overall max
  logic vld_c, rdy_c;
  logic [NWHEEL-1:0]            neg_c;
  logic [NWHEEL-1:0][MAG_W-1:0] mag_c;
  mag_t m_c;
  logic scale_c;
  // stage d: first quotient bit
  logic rdy_d;

  sum_t f, s, t;
  logic [NWHEEL-1:0][SUM_W-1:0] p_next;
  logic [NWHEEL-1:0]            neg_next;
  logic [NWHEEL-1:0][MAG_W-1:0] mag_next;
  mag_t m_next;
  div_t d_next;

  assign rdy_d  = !dn_vld || dn_rdy;
  assign rdy_c  = !vld_c || rdy_d;
  assign rdy_b  = !vld_b || rdy_c;
  assign rdy_a  = !vld_a || rdy_b;
  assign up_rdy = rdy_a;

  always_comb begin
    f = SUM_W'(forward_cmd);
    s = SUM_W'(strafe_cmd);
    t = SUM_W'(turn_cmd);
    p_next[0] = f + s - t;
    p_next[1] = f - s + t;
    p_next[2] = f - s - t;
    p_next[3] = f + s + t;
  end

  always_comb begin
    for (int i = 0; i < NWHEEL; i++) begin
      neg_next[i] = p_a[i][SUM_W-1];
      mag_next[i] = neg_next[i] ? MAG_W'(-p_a[i]) : MAG_W'(p_a[i]);
    end
  end

  assign m_next = (max01_b >= max23_b) ? max01_b : max23_b;

  always_comb begin
    d_next.scale = scale_c;
    d_next.m     = m_c;
    d_next.neg   = neg_c;
    for (int i = 0; i < NWHEEL; i++) begin
      if (scale_c) begin
        // magnitude never exceeds the max, so the top bit is 1 only when equal
        d_next.rem[i] = (mag_c[i] >= m_c) ? (mag_c[i] - m_c) : mag_c[i];
        d_next.quo[i] = QUO_W'(mag_c[i] >= m_c);
      end else begin
        d_next.rem[i] = '0;
        d_next.quo[i] = QUO_W'(mag_c[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a  <= 1'b0;
      vld_b  <= 1'b0;
      vld_c  <= 1'b0;
      dn_vld <= 1'b0;
    end else begin
      if (rdy_a) vld_a  <= up_vld;
      if (rdy_b) vld_b  <= vld_a;
      if (rdy_c) vld_c  <= vld_b;
      if (rdy_d) dn_vld <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (up_vld && rdy_a) begin
      p_a <= p_next;
    end
    if (vld_a && rdy_b) begin
      neg_b   <= neg_next;
      mag_b   <= mag_next;
      max01_b <= (mag_next[0] >= mag_next[1]) ? mag_next[0] : mag_next[1];
      max23_b <= (mag_next[2] >= mag_next[3]) ? mag_next[2] : mag_next[3];
    end
    if (vld_b && rdy_c) begin
      neg_c   <= neg_b;
      mag_c   <= mag_b;
      m_c     <= m_next;
      scale_c <= m_next > ONE_MAG;
    end
    if (vld_c && rdy_d) begin
      dn_data <= d_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mwpm_div_step.sv]
`default_nettype none
module mwpm_div_step import mwpm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic up_vld,
  output logic      up_rdy,
  input  wire div_t up_data,
  output logic      dn_vld,
  input  wire logic dn_rdy,
  output div_t      dn_data
);

  div_t data_next;
  logic [MAG_W:0] r2;
  logic           b;

  assign up_rdy = !dn_vld || dn_rdy;

  // one restoring step per wheel when scaling, else the word passes unchanged; remainder stays below the max
  always_comb begin
    data_next = up_data;
    r2 = '0;
    b  = 1'b0;
    if (up_data.scale) begin
      for (int i = 0; i < NWHEEL; i++) begin
        r2 = {up_data.rem[i], 1'b0};
        b  = r2 >= {1'b0, up_data.m};
        data_next.rem[i] = b ? MAG_W'(r2 - {1'b0, up_data.m}) : MAG_W'(r2);
        data_next.quo[i] = {up_data.quo[i][QUO_W-2:0], b};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else if (up_rdy) begin
      dn_vld <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_vld && up_rdy) begin
      dn_data <= data_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mwpm_out.sv]
`default_nettype none
module mwpm_out import mwpm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_vld,
  output logic                      up_rdy,
  input  wire div_t                 up_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [CMD_W-1:0]   front_left_power,
  output logic signed [CMD_W-1:0]   front_right_power,
  output logic signed [CMD_W-1:0]   back_left_power,
  output logic signed [CMD_W-1:0]   back_right_power
);

  logic signed [CMD_W-1:0] x;
  logic signed [CMD_W-1:0] v;
  logic [NWHEEL-1:0][CMD_W-1:0] pwr_next;

  assign up_rdy = !out_valid || out_ready;

  always_comb begin
    x = '0;
    v = '0;
    for (int i = 0; i < NWHEEL; i++) begin
      x = CMD_W'(up_data.quo[i]);
      v = up_data.neg[i] ? -x : x;
      if (v > POS_ONE) begin
        pwr_next[i] = POS_ONE;
      end else if (v < NEG_ONE) begin
        pwr_next[i] = NEG_ONE;
      end else begin
        pwr_next[i] = v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_rdy) begin
      out_valid <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_vld && up_rdy) begin
      front_left_power  <= pwr_next[0];
      front_right_power <= pwr_next[1];
      back_left_power   <= pwr_next[2];
      back_right_power  <= pwr_next[3];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mecanum_wheel_power_mixer.sv]
// Path from an accepted command to its wheel powers: 4 front-end stages,
// 14 divider steps, 1 output register. Throughput: one command per cycle while
// out_ready does not stall; the 14-stage restoring divider is fully pipelined.
// Stalls hold each stage in place; bubbles close up, so nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipe; no other state is kept.
`default_nettype none
module mecanum_wheel_power_mixer import mwpm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [CMD_W-1:0] forward_cmd,
  input  wire logic signed [CMD_W-1:0] strafe_cmd,
  input  wire logic signed [CMD_W-1:0] turn_cmd,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [CMD_W-1:0]      front_left_power,
  output logic signed [CMD_W-1:0]      front_right_power,
  output logic signed [CMD_W-1:0]      back_left_power,
  output logic signed [CMD_W-1:0]      back_right_power
);

  logic [DIV_STEPS:0] vld;
  logic [DIV_STEPS:0] rdy;
  div_t               data [DIV_STEPS+1];

  mwpm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .up_vld      (in_valid),
    .up_rdy      (in_ready),
    .forward_cmd (forward_cmd),
    .strafe_cmd  (strafe_cmd),
    .turn_cmd    (turn_cmd),
    .dn_vld      (vld[0]),
    .dn_rdy      (rdy[0]),
    .dn_data     (data[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    mwpm_div_step u_step (
      .clk     (clk),
      .rst     (rst),
      .up_vld  (vld[k]),
      .up_rdy  (rdy[k]),
      .up_data (data[k]),
      .dn_vld  (vld[k+1]),
      .dn_rdy  (rdy[k+1]),
      .dn_data (data[k+1])
    );
  end

  mwpm_out u_out (
    .clk               (clk),
    .rst               (rst),
    .up_vld            (vld[DIV_STEPS]),
    .up_rdy            (rdy[DIV_STEPS]),
    .up_data           (data[DIV_STEPS]),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .front_left_power  (front_left_power),
    .front_right_power (front_right_power),
    .back_left_power   (back_left_power),
    .back_right_power  (back_right_power)
  );

endmodule
`default_nettype wire

[hw/rtl/mwpm_checker.sv]
`default_nettype none
module mwpm_checker import mwpm_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [CMD_W-1:0] front_left_power,
  input wire logic signed [CMD_W-1:0] front_right_power,
  input wire logic signed [CMD_W-1:0] back_left_power,
  input wire logic signed [CMD_W-1:0] back_right_power
);

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // every delivered power is within +-1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (front_left_power  <= POS_ONE && front_left_power  >= NEG_ONE &&
                   front_right_power <= POS_ONE && front_right_power >= NEG_ONE &&
                   back_left_power   <= POS_ONE && back_left_power   >= NEG_ONE &&
                   back_right_power  <= POS_ONE && back_right_power  >= NEG_ONE))
    else $error("wheel power out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(front_left_power) && $stable(front_right_power) &&
                                $stable(back_left_power) && $stable(back_right_power))
    else $error("output word changed while stalled");

endmodule

bind mecanum_wheel_power_mixer mwpm_checker u_mwpm_checker (.*);
`default_nettype wire

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mwpm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_LATENCY = 19;
  localparam int RAND_PER_PHASE = 125;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int N_DIR = 22;
  localparam int N_PHASE = 4;

  typedef struct packed {
    logic signed [CMD_W-1:0] fwd;
    logic signed [CMD_W-1:0] str;
    logic signed [CMD_W-1:0] trn;
  } drive_cmd_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] fl;
    logic signed [CMD_W-1:0] fr;
    logic signed [CMD_W-1:0] bl;
    logic signed [CMD_W-1:0] br;
  } wheel_powers_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CMD_W-1:0] forward_cmd = '0;
  logic signed [CMD_W-1:0] strafe_cmd = '0;
  logic signed [CMD_W-1:0] turn_cmd = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CMD_W-1:0] front_left_power;
  logic signed [CMD_W-1:0] front_right_power;
  logic signed [CMD_W-1:0] back_left_power;
  logic signed [CMD_W-1:0] back_right_power;

  wheel_powers_t expected_powers_q[$];
  int mismatches = 0;
  int cmds_sent = 0;
  int words_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cnt = 0;
  int cycle_cnt = 0;

  // f, s, t, typed, fl, fr, bl, br; untyped rows go through the predictor
  int dir_tab [N_DIR][8] = '{
    '{0, 0, 0, 1, 0, 0, 0, 0},
    '{16384, 0, 0, 1, 16384, 16384, 16384, 16384},
    '{-16384, 0, 0, 1, -16384, -16384, -16384, -16384},
    '{0, 16384, 0, 1, 16384, -16384, -16384, 16384},
    '{0, 0, 16384, 1, -16384, 16384, -16384, 16384},
    '{8192, 8192, 0, 1, 16384, 0, 0, 16384},
    '{8192, -4096, 4096, 1, 0, 16384, 8192, 8192},
    '{16385, 0, 0, 1, 16384, 16384, 16384, 16384},
    '{32767, 0, 0, 1, 16384, 16384, 16384, 16384},
    '{-32768, 0, 0, 1, -16384, -16384, -16384, -16384},
    '{0, -32768, 0, 1, -16384, 16384, 16384, -16384},
    '{0, 0, -32768, 1, 16384, -16384, 16384, -16384},
    '{-32768, -32768, -32768, 1, -5461, -5461, 5461, -16384},
    '{16384, 16384, 16384, 1, 5461, 5461, -5461, 16384},
    '{1, 0, 0, 1, 1, 1, 1, 1},
    '{-1, -1, -1, 1, -1, -1, 1, -3},
    '{32767, 32767, 32767, 0, 0, 0, 0, 0},
    '{32767, -32768, 32767, 0, 0, 0, 0, 0},
    '{21845, -21846, 21845, 0, 0, 0, 0, 0},
    '{-21846, 21845, -21846, 0, 0, 0, 0, 0},
    '{12000, 9000, -7000, 0, 0, 0, 0, 0},
    '{1, -1, 1, 0, 0, 0, 0, 0}
  };

  int phase_send_idle [N_PHASE] = '{0, 56, 0, 37};
  int phase_recv_stall [N_PHASE] = '{0, 0, 56, 37};

  mecanum_wheel_power_mixer uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .forward_cmd      (forward_cmd),
    .strafe_cmd       (strafe_cmd),
    .turn_cmd         (turn_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .front_left_power (front_left_power),
    .front_right_power(front_right_power),
    .back_left_power  (back_left_power),
    .back_right_power (back_right_power)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [CMD_W-1:0] clamp_unit(longint v);
    if (v > 16384) begin
      return POS_ONE;
    end
    if (v < -16384) begin
      return NEG_ONE;
    end
    return CMD_W'(v);
  endfunction

  function automatic wheel_powers_t mix_wheel_powers(drive_cmd_t c);
    longint f;
    longint s;
    longint t;
    longint peak;
    longint mag;
    longint p [4];
    wheel_powers_t r;
    f = c.fwd;
    s = c.str;
    t = c.trn;
    p[0] = f + s - t;
    p[1] = f - s + t;
    p[2] = f - s - t;
    p[3] = f + s + t;
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      mag = (p[i] < 0) ? -p[i] : p[i];
      if (mag > peak) begin
        peak = mag;
      end
    end
    // rescale only above 1.0; signed division truncates toward zero
    if (peak > 16384) begin
      for (int i = 0; i < 4; i++) begin
        p[i] = (p[i] * 16384) / peak;
      end
    end
    r.fl = clamp_unit(p[0]);
    r.fr = clamp_unit(p[1]);
    r.bl = clamp_unit(p[2]);
    r.br = clamp_unit(p[3]);
    return r;
  endfunction

  function automatic logic signed [CMD_W-1:0] random_field();
    int kind;
    kind = $urandom_range(9);
    if (kind < 5) begin
      return CMD_W'($urandom);
    end
    if (kind < 8) begin
      // ordinary drive range, within +-1.0
      return CMD_W'(int'($urandom_range(32768)) - 16384);
    end
    case ($urandom_range(5))
      0: return CMD_W'(0);
      1: return POS_ONE;
      2: return NEG_ONE;
      3: return CMD_W'(32767);
      4: return CMD_W'(-32768);
      default: return CMD_W'(8192);
    endcase
  endfunction

  function automatic drive_cmd_t random_cmd();
    drive_cmd_t c;
    c.fwd = random_field();
    c.str = random_field();
    c.trn = random_field();
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic signed [CMD_W-1:0] got,
                             logic signed [CMD_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("word %0d %s got %0d want %0d",
                                words_checked, name, got, want));
    end
  endtask

  task automatic send_cmd(drive_cmd_t c, bit typed, wheel_powers_t typed_exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    forward_cmd <= c.fwd;
    strafe_cmd <= c.str;
    turn_cmd <= c.trn;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    expected_powers_q.push_back(typed ? typed_exp : mix_wheel_powers(c));
    cmds_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_powers_q.size() != 0);
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    wheel_powers_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_powers_q.size() == 0) begin
        report_mismatch("wheel-power word with nothing expected");
      end else begin
        want = expected_powers_q.pop_front();
        check_field("front_left", front_left_power, want.fl);
        check_field("front_right", front_right_power, want.fr);
        check_field("back_left", back_left_power, want.bl);
        check_field("back_right", back_right_power, want.br);
      end
      words_checked++;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d words outstanding",
             cycle_cnt, expected_powers_q.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    drive_cmd_t c;
    wheel_powers_t w;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      c.fwd = CMD_W'(dir_tab[i][0]);
      c.str = CMD_W'(dir_tab[i][1]);
      c.trn = CMD_W'(dir_tab[i][2]);
      w.fl = CMD_W'(dir_tab[i][4]);
      w.fr = CMD_W'(dir_tab[i][5]);
      w.bl = CMD_W'(dir_tab[i][6]);
      w.br = CMD_W'(dir_tab[i][7]);
      send_cmd(c, dir_tab[i][3] != 0, w);
    end
    wait_drained();

    for (int ph = 0; ph < N_PHASE; ph++) begin
      send_idle_pct = phase_send_idle[ph];
      recv_stall_pct = phase_recv_stall[ph];
      // back-pressure: output blocked while commands keep coming, pipe fills up
      if (ph == 0) begin
        hold_cnt = HOLD_OFF_CYCLES;
      end
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        send_cmd(random_cmd(), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (PIPE_LATENCY * 2) @(posedge clk);
    $display("covered %0d commands (%0d directed) in %0d idle/stall phases",
             cmds_sent, N_DIR, N_PHASE);
    $display("checked %0d wheel-power words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && expected_powers_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[mecanum_wheel_power_mixer.f]
hw/rtl/mwpm_pkg.sv
hw/rtl/mwpm_front.sv
hw/rtl/mwpm_div_step.sv
hw/rtl/mwpm_out.sv
hw/rtl/mecanum_wheel_power_mixer.sv
hw/rtl/mwpm_checker.sv
test/tb_top.sv
